>>> src/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    // Stop status codes reported on the end-of-buffer result
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD = 3'd1;
    localparam logic [2:0] ST_BAD_SEQ  = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;

    localparam int CP_W = 21;

    // Byte order mark as a decoded code point and its lead byte
    localparam logic [CP_W-1:0] BOM_CP   = 21'h00FEFF;
    localparam logic [7:0]      BOM_LEAD = 8'hEF;

    // Decoder state carried from beat to beat
    typedef struct packed {
        logic [CP_W-1:0] partial;
        logic [1:0]      need;
        logic            at_start;
        logic            maybe_bom;
        logic            halted;
        logic [2:0]      reason;
    } t_dec_state;

    localparam t_dec_state DEC_RESET = '{
        partial:   '0,
        need:      2'd0,
        at_start:  1'b1,
        maybe_bom: 1'b0,
        halted:    1'b0,
        reason:    ST_OK
    };

    // One result beat
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            has_cp;
        logic            eos;
        logic [2:0]      status;
    } t_dec_result;

endpackage

`default_nettype wire

>>> src/u8sd_step.sv
// Combinational next-state and result logic for one input byte.
`default_nettype none

module u8sd_step (
    input  wire u8sd_pkg::t_dec_state  i_state,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    output u8sd_pkg::t_dec_state       o_state,
    output u8sd_pkg::t_dec_result      o_result
);
    import u8sd_pkg::*;

    t_dec_state      n_s;
    logic            done;
    logic            have;
    logic [CP_W-1:0] cp;

    always_comb begin
        n_s  = i_state;
        done = 1'b0;
        have = 1'b0;
        cp   = '0;

        if (!i_state.halted) begin
            if (i_state.need == 2'd0) begin
                // Classify the lead byte
                if (i_byte[7] == 1'b0) begin
                    n_s.partial = {13'd0, i_byte};
                    done        = 1'b1;
                end else if (i_byte[7:5] == 3'b110) begin
                    n_s.partial = {16'd0, i_byte[4:0]};
                    n_s.need    = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_s.partial   = {17'd0, i_byte[3:0]};
                    n_s.need      = 2'd2;
                    n_s.maybe_bom = i_state.at_start && (i_byte == BOM_LEAD);
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_s.partial = {18'd0, i_byte[2:0]};
                    n_s.need    = 2'd3;
                end else begin
                    n_s.halted    = 1'b1;
                    n_s.reason    = ST_BAD_LEAD;
                    n_s.need      = 2'd0;
                    n_s.maybe_bom = 1'b0;
                end
            end else if (i_byte[7:6] == 2'b10) begin
                // Shift in six payload bits of a trailing byte
                n_s.partial = {i_state.partial[CP_W-7:0], i_byte[5:0]};
                n_s.need    = i_state.need - 2'd1;
                done        = (i_state.need == 2'd1);
            end else begin
                n_s.halted    = 1'b1;
                n_s.reason    = ST_BAD_SEQ;
                n_s.need      = 2'd0;
                n_s.maybe_bom = 1'b0;
            end

            // Finish a code point: halt on zero, drop a leading mark
            if (done) begin
                if (n_s.partial == '0) begin
                    n_s.halted = 1'b1;
                    n_s.reason = ST_ZERO;
                    n_s.need   = 2'd0;
                end else if (!(i_state.maybe_bom && n_s.partial == BOM_CP)) begin
                    cp   = n_s.partial;
                    have = 1'b1;
                end
                n_s.maybe_bom = 1'b0;
                n_s.partial   = '0;
            end

            // Buffer ends inside a sequence
            if (i_last && !n_s.halted && n_s.need != 2'd0) begin
                n_s.halted    = 1'b1;
                n_s.reason    = ST_BAD_SEQ;
                n_s.need      = 2'd0;
                n_s.maybe_bom = 1'b0;
            end
        end
        n_s.at_start = 1'b0;

        o_result.emit       = i_last || have;
        o_result.code_point = cp;
        o_result.has_cp     = have;
        o_result.eos        = i_last;
        o_result.status     = (i_last && n_s.halted) ? n_s.reason : ST_OK;

        // Start a fresh buffer after the last byte
        o_state = i_last ? DEC_RESET : n_s;
    end

endmodule

`default_nettype wire

>>> src/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: input register, decode, result register.
//
// Usage:
//   Slave channel (i_s_*) takes one buffer byte per beat; i_s_tlast marks the
//   buffer's final byte. Master channel (o_m_*) gives one beat per decoded
//   code point, and exactly one end beat (o_m_tlast high) for the final byte,
//   which carries any code point that byte completes; its tuser status tells
//   why decoding stopped. A dropped byte order mark gives no beat; after a halt,
//   bytes produce no beat until the end of the buffer. A completing byte is
//   held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the master side is ready; the decode step is a single
//   level of shift/mask logic plus the state register update.
// Stall: while i_m_tready is low and a result is held, the decode stage
//   stops; the input register still takes one more beat before o_s_tready
//   drops. With both registers full, o_s_tready follows i_m_tready.
// Reset: i_rst_n low (synchronous) empties both registers and returns the
//   decoder to the start-of-buffer state.
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // end_of_buffer
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [3:0]       o_m_tuser,   // [0] has_code_point, [3:1] stop_status
    output logic             o_m_tlast    // end_of_string
);
    import u8sd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result n_result;
    logic        r_out_valid;
    t_dec_result r_out;
    logic        out_free;
    logic        advance;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;

    u8sd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Input register: load a beat when empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Decoder state: advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DEC_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.emit;
        end
        if (advance && n_result.emit) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.code_point};
    assign o_m_tuser  = {r_out.status, r_out.has_cp};
    assign o_m_tlast  = r_out.eos;

    // A beat without a code point can only be the end beat
    a_nocp_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast)
        else $error("result without code point that is not the end beat");

    // Non-end beats always report ok status
    a_mid_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser[3:1] == ST_OK)
        else $error("nonzero status on a non-end beat");

    // Decoding the last byte returns the decoder to buffer start
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state.at_start && !r_state.halted
            && r_state.need == 2'd0)
        else $error("state not cleared after end of buffer");

    // A halted decoder is never waiting for trailing bytes
    a_halt_no_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> r_state.need == 2'd0 && r_state.reason != ST_OK)
        else $error("halted state inconsistent");

endmodule

`default_nettype wire

>>> tb/sv/utf8_stream_decoder_checker.sv
// Scoreboard for the UTF-8 stream decoder: predicts result beats from input beats and compares.
module utf8_stream_decoder_checker
    import u8sd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // end_of_buffer
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic [3:0]  i_m_tuser,   // [0] has_code_point, [3:1] stop_status
    input  wire logic        i_m_tlast,   // end_of_string
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_cp;
        logic            eos;
        logic [2:0]      status;
    } t_cp_beat;

    // Result beats still owed by the block, oldest first
    t_cp_beat expected_beats[$];

    // Predicted decoder state
    logic [CP_W-1:0] acc_cp        = '0;
    logic [1:0]      trail_due     = 2'd0;
    logic            first_byte    = 1'b1;
    logic            bom_candidate = 1'b0;
    logic            stopped       = 1'b0;
    logic [2:0]      stop_code     = ST_OK;
    int              fails         = 0;
    int              checked       = 0;

    task automatic restart_buffer();
        acc_cp        = '0;
        trail_due     = 2'd0;
        first_byte    = 1'b1;
        bom_candidate = 1'b0;
        stopped       = 1'b0;
        stop_code     = ST_OK;
    endtask

    task automatic stop_decoding(input logic [2:0] code);
        stopped       = 1'b1;
        stop_code     = code;
        trail_due     = 2'd0;
        bom_candidate = 1'b0;
    endtask

    // Advance the predicted decoder by one byte and queue any result it causes
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic            complete;
        logic            emit;
        logic [CP_W-1:0] value;
        complete = 1'b0;
        emit     = 1'b0;
        value    = '0;
        if (!stopped) begin
            if (trail_due == 2'd0) begin
                if (b[7] == 1'b0) begin
                    acc_cp   = CP_W'(b);
                    complete = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    acc_cp    = CP_W'(b[4:0]);
                    trail_due = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    acc_cp        = CP_W'(b[3:0]);
                    trail_due     = 2'd2;
                    bom_candidate = first_byte && (b == BOM_LEAD);
                end else if (b[7:3] == 5'b11110) begin
                    acc_cp    = CP_W'(b[2:0]);
                    trail_due = 2'd3;
                end else begin
                    stop_decoding(ST_BAD_LEAD);
                end
            end else if (b[7:6] == 2'b10) begin
                acc_cp    = {acc_cp[CP_W-7:0], b[5:0]};
                trail_due = trail_due - 2'd1;
                if (trail_due == 2'd0)
                    complete = 1'b1;
            end else begin
                stop_decoding(ST_BAD_SEQ);
            end

            // Finish a code point: zero halts, a leading byte order mark is dropped
            if (complete) begin
                if (acc_cp == '0) begin
                    stop_decoding(ST_ZERO);
                end else if (!(bom_candidate && acc_cp == BOM_CP)) begin
                    value = acc_cp;
                    emit  = 1'b1;
                end
                bom_candidate = 1'b0;
                acc_cp        = '0;
            end

            if (last && !stopped && trail_due != 2'd0)
                stop_decoding(ST_BAD_SEQ);
        end
        first_byte = 1'b0;

        if (last) begin
            expected_beats.push_back('{value, emit, 1'b1, stopped ? stop_code : ST_OK});
            restart_buffer();
        end else if (emit) begin
            expected_beats.push_back('{value, 1'b1, 1'b0, ST_OK});
        end
    endtask

    task automatic check_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // Compare one result beat against the oldest expectation
    task automatic compare_beat();
        t_cp_beat want;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
                   i_m_tdata, i_m_tuser, i_m_tlast);
            fails++;
        end else begin
            want = expected_beats.pop_front();
            checked++;
            check_field("code_point", want.code_point, i_m_tdata[CP_W-1:0]);
            check_field("tdata_pad", '0, CP_W'(i_m_tdata[23:CP_W]));
            check_field("has_code_point", CP_W'(want.has_cp), CP_W'(i_m_tuser[0]));
            check_field("stop_status", CP_W'(want.status), CP_W'(i_m_tuser[3:1]));
            check_field("end_of_string", CP_W'(want.eos), CP_W'(i_m_tlast));
        end
    endtask

    // Sample both channels at the edge; drain the output before predicting new input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_buffer();
            expected_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                compare_beat();
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= expected_beats.size();
        o_checked    <= checked;
    end

endmodule

>>> tb/sv/utf8_stream_decoder_core_tb.sv
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module utf8_stream_decoder_core_tb;

    typedef logic [7:0] t_byte_q[$];

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 64;
    localparam int PHASE_ITEMS    = 320;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire  [3:0]  m_tuser;
    wire         m_tlast;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int items_sent     = 0;
    int buffers_sent   = 0;

    int phase_send_idle[4]  = '{0, 81, 0, 7};
    int phase_recv_stall[4] = '{0, 0, 81, 7};

    utf8_stream_decoder_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    utf8_stream_decoder_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    // Drive tready: a requested long hold-off first, otherwise random stalls
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_tready  <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("** utf8_stream_decoder_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one buffer, flagging its final byte with tlast
    task automatic send_text(input t_byte_q text);
        foreach (text[k]) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text[k];
            s_tlast  <= (k == text.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            items_sent++;
        end
        buffers_sent++;
    endtask

    // Hold the sender off until every owed result beat has arrived
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Build a buffer of mostly well-formed sequences with random payload bits
    function automatic t_byte_q random_text();
        t_byte_q     text;
        int          n_chars;
        int          kind;
        logic [20:0] cp;
        text = {};
        if ($urandom_range(0, 7) == 0)
            text = '{8'hEF, 8'hBB, 8'hBF};
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
            kind = $urandom_range(0, 39);
            cp   = 21'($urandom());
            if (kind < 16) begin
                text.push_back({1'b0, cp[6:0]});
            end else if (kind < 24) begin
                text.push_back({3'b110, cp[10:6]});
                text.push_back({2'b10, cp[5:0]});
            end else if (kind < 31) begin
                text.push_back({4'b1110, cp[15:12]});
                text.push_back({2'b10, cp[11:6]});
                text.push_back({2'b10, cp[5:0]});
            end else if (kind < 36) begin
                text.push_back({5'b11110, cp[20:18]});
                text.push_back({2'b10, cp[17:12]});
                text.push_back({2'b10, cp[11:6]});
                text.push_back({2'b10, cp[5:0]});
            end else if (kind == 36) begin
                text.push_back(cp[7:0]);
            end else if (kind == 37) begin
                text.push_back({2'b10, cp[5:0]});
            end else if (kind == 38) begin
                // three-byte sequence cut short by one byte
                text.push_back({4'b1110, cp[15:12]});
                text.push_back({2'b10, cp[11:6]});
            end else begin
                text.push_back({5'b11111, cp[2:0]});
            end
        end
        return text;
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed buffers: edge values and each stop reason
        send_text('{8'h41});
        send_text('{8'hEF, 8'hBB, 8'hBF});
        send_text('{8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
        send_text('{8'h80, 8'h41});
        send_text('{8'hF8});
        send_text('{8'hE2, 8'h82});
        send_text('{8'hE2, 8'h41});
        send_text('{8'hC0, 8'h80});
        send_text('{8'h00});
        send_text('{8'h41, 8'hEF, 8'hBB, 8'hBF});
        wait_for_drain();

        // Random buffers under each flow-control mix
        for (int phase = 0; phase < 4; phase++) begin
            int phase_start;
            phase_start    = items_sent;
            send_idle_pct  = phase_send_idle[phase];
            recv_stall_pct = phase_recv_stall[phase];
            while (items_sent < phase_start + PHASE_ITEMS) begin
                if (phase == 0 && hold_req == 0 && items_sent >= phase_start + 100)
                    hold_req = 1;
                send_text(random_text());
            end
            wait_for_drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d bytes in %0d buffers: valid text, byte order marks, bad leads,",
                 items_sent, buffers_sent);
        $display("short and broken sequences, zeros; %0d result beats checked", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** utf8_stream_decoder_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("** utf8_stream_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
